/* rtl/m4vt_pkg.sv */
// Shared types and constants for the 4x4 matrix-vector transform block.
// Holds field widths, the request mode codes and the queued command type.
// No dependencies.
package m4vt_pkg;

  localparam int WORD_W    = 32;
  localparam int IDX_W     = 4;
  localparam int DIM       = 4;
  localparam int ENTRIES   = DIM * DIM;

  // Stream payload widths; input tdata is padded to whole bytes.
  localparam int S_FIELDS_W = IDX_W + WORD_W + DIM * WORD_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = DIM * WORD_W;

  // Command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Datapath widths: product, pair sum, row sum with rounding term.
  localparam int PROD_W = 2 * WORD_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic [WORD_W-1:0] SAT_POS = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_NEG = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_XFORM = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                        mode;
    logic [IDX_W-1:0]             entry_index;
    logic [WORD_W-1:0]            entry_value;
    logic [DIM-1:0][WORD_W-1:0]   vec;
  } cmd_t;

endpackage

/* rtl/matrix4_vector_transform.sv */
// Top level of the 4x4 matrix times 4-vector block in signed fixed point.
// Depends on m4vt_pkg, m4vt_front and m4vt_back.
//
//  Channel   Direction  tdata (low bit up)                        tuser
//  s_axis    in         entry_index, entry_value, vec_x..vec_w    mode
//  m_axis    out        res_x, res_y, res_z, res_w                saturated
//
// One request is taken every cycle while the queue has room. An accepted
// transform passes through the queue and then the registered multiply,
// pair-add, row-add and saturate stages. A load updates the stored matrix
// as it leaves the queue and never overtakes or lags an earlier transform.
// Reset sets the matrix to the identity and empties the queue at once.
// When the output stalls, the pipeline holds and the four-entry queue keeps
// taking requests until it fills; s_axis_tready drops only then.
module matrix4_vector_transform import m4vt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: entry_index[3:0], entry_value[35:4], vec_x[67:36],
  // vec_y[99:68], vec_z[131:100], vec_w[163:132]; top bits are zero fill.
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // Field: mode (0 loads one matrix entry, 1 transforms a vector).
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Fields from bit 0: res_x[31:0], res_y[63:32], res_z[95:64], res_w[127:96].
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // Field: saturated (any component clipped to the 32-bit range).
  output logic                 m_axis_tuser
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // The front decodes each request and queues it in arrival order.
  m4vt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  // The back applies loads to the matrix and runs transforms through the
  // multiply and accumulate pipeline, ending in the output register.
  m4vt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* rtl/m4vt_front.sv */
// Front end: accepts stream requests, decodes them into commands and queues them.
// Depends on m4vt_pkg.
module m4vt_front import m4vt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,
  output logic                 q_valid,
  output cmd_t                 q_cmd,
  input  logic                 q_pop
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              cmd_in;
  logic              push;

  always_comb begin
    cmd_in.mode        = mode_t'(s_axis_tuser);
    cmd_in.entry_index = s_axis_tdata[IDX_W-1:0];
    cmd_in.entry_value = s_axis_tdata[IDX_W +: WORD_W];
    for (int i = 0; i < DIM; i++) begin
      cmd_in.vec[i] = s_axis_tdata[IDX_W + WORD_W + i*WORD_W +: WORD_W];
    end
  end

  assign s_axis_tready = (count != QCNT_W'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign q_cmd         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

endmodule

/* rtl/m4vt_back.sv */
// Back end: matrix store and the multiply, sum, round and saturate pipeline.
// Depends on m4vt_pkg; fed by the command queue in m4vt_front.
module m4vt_back import m4vt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  cmd_t                 q_cmd,
  output logic                 q_pop,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tuser
);

  localparam logic [WORD_W-1:0]       ONE   = WORD_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) << (FRAC_BITS - 1);
  localparam int                      HI_W  = SUM_W - WORD_W + 1;

  logic [WORD_W-1:0]        mat [ENTRIES];
  logic                     adv;
  logic                     a_valid, b_valid, c_valid;
  logic signed [PROD_W-1:0] prod [ENTRIES];
  logic signed [PAIR_W-1:0] pair_lo [DIM];
  logic signed [PAIR_W-1:0] pair_hi [DIM];
  logic signed [SUM_W-1:0]  total [DIM];
  logic signed [SUM_W-1:0]  shifted [DIM];
  logic [DIM-1:0][WORD_W-1:0] res;
  logic [DIM-1:0]           clip;
  logic [HI_W-1:0]          hi_bits [DIM];

  // The whole pipeline moves together; it freezes only while a result waits.
  assign adv   = !m_axis_tvalid || m_axis_tready;
  assign q_pop = q_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        mat[i] <= (i % (DIM + 1) == 0) ? ONE : '0;
      end
    end else if (q_pop && q_cmd.mode == MODE_LOAD) begin
      mat[q_cmd.entry_index] <= q_cmd.entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      c_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      a_valid       <= q_pop && q_cmd.mode == MODE_XFORM;
      b_valid       <= a_valid;
      c_valid       <= b_valid;
      m_axis_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          prod[r*DIM + c] <= $signed(mat[r*DIM + c]) * $signed(q_cmd.vec[c]);
        end
        pair_lo[r] <= PAIR_W'(prod[r*DIM])     + PAIR_W'(prod[r*DIM + 1]);
        pair_hi[r] <= PAIR_W'(prod[r*DIM + 2]) + PAIR_W'(prod[r*DIM + 3]);
        total[r]   <= SUM_W'(pair_lo[r]) + SUM_W'(pair_hi[r]) + ROUND;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      shifted[r] = total[r] >>> FRAC_BITS;
      hi_bits[r] = shifted[r][SUM_W-1:WORD_W-1];
      clip[r]    = (hi_bits[r] != '0) && (hi_bits[r] != '1);
      if (clip[r]) begin
        res[r] = shifted[r][SUM_W-1] ? SAT_NEG : SAT_POS;
      end else begin
        res[r] = shifted[r][WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && c_valid) begin
      m_axis_tdata <= res;
      m_axis_tuser <= |clip;
    end
  end

endmodule

/* rtl/m4vt_checker.sv */
// Port-level checks for the matrix-vector transform top level, bound to it.
// Depends on matrix4_vector_transform's port list only.
module m4vt_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // No result is presented right after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A waiting result holds its data.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // The queue can only fill through an accepted request.
  assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("input ready dropped without a request");

  // A saturation flag means some component sits at a bound.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[31:0] == 32'h7FFFFFFF || m_axis_tdata[31:0] == 32'h80000000 ||
      m_axis_tdata[63:32] == 32'h7FFFFFFF || m_axis_tdata[63:32] == 32'h80000000 ||
      m_axis_tdata[95:64] == 32'h7FFFFFFF || m_axis_tdata[95:64] == 32'h80000000 ||
      m_axis_tdata[127:96] == 32'h7FFFFFFF || m_axis_tdata[127:96] == 32'h80000000)
    else $error("saturation flag without a clipped component");

endmodule

bind matrix4_vector_transform m4vt_checker u_m4vt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
